// File: rtl/core/hgs_pkg.sv
// shared types, constants and register codes of the hex grid snap unit
`timescale 1ns / 1ps
`default_nettype none

package hgs_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HEX_RADIUS       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_HEIGHT     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_HEX_RADIUS   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LAYER_HEIGHT = 8'd3;

  localparam logic [23:0] HEX_RADIUS_RST       = 24'd25600;
  localparam logic [23:0] LAYER_HEIGHT_RST     = 24'd25600;
  localparam logic [31:0] INV_HEX_RADIUS_RST   = 32'd167772;
  localparam logic [31:0] INV_LAYER_HEIGHT_RST = 32'd167772;

  // constants scaled by 2^30
  localparam logic [29:0] K_S3_3     = 30'd619925131;
  localparam logic [28:0] K_THIRD    = 29'd357913941;
  localparam logic [29:0] K_TWOTHIRD = 30'd715827883;
  localparam logic [30:0] K_SQRT3    = 31'd1859775393;

  localparam int SCALE_STAGES = 5;
  localparam int ROUND_STAGES = 7;
  localparam int MAP_STAGES   = 7;
  localparam int NUM_STAGES   = SCALE_STAGES + ROUND_STAGES + MAP_STAGES;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] cell_q;
    logic signed [15:0] cell_r;
    logic signed [15:0] cell_layer;
    logic signed [31:0] snap_x;
    logic signed [31:0] snap_y;
    logic signed [31:0] snap_z;
  } out_item_t;

  // fractional q, r and layer as magnitude and sign, 16 fraction bits
  typedef struct packed {
    logic [47:0] mag_q;
    logic [47:0] mag_r;
    logic [47:0] mag_z;
    logic        neg_q;
    logic        neg_r;
    logic        neg_z;
  } hgs_frac_t;

  typedef struct packed {
    logic signed [15:0] q;
    logic signed [15:0] r;
    logic signed [15:0] layer;
  } hgs_cell_t;

endpackage

`default_nettype wire

// File: rtl/core/hgs_scale.sv
// front pipeline: constant products, reciprocal scaling to fractional q, r and layer
`timescale 1ns / 1ps
`default_nettype none

module hgs_scale (
  input  logic                             clk,
  input  logic [hgs_pkg::SCALE_STAGES-1:0] stage_en,
  input  hgs_pkg::in_item_t                in_data,
  input  logic [31:0]                      inv_hex_radius,
  input  logic [31:0]                      inv_layer_height,
  output hgs_pkg::hgs_frac_t               frac
);
  import hgs_pkg::*;

  logic signed [62:0] px_r, py_r, pr_r;
  logic signed [31:0] z_r;
  logic signed [63:0] nq_r, nr_r, nz_r;
  logic [61:0]        mq_r, mr_r, mz_r;
  logic [2:0]         neg2_r, neg3_r, neg4_r;
  logic [63:0]        lo_q_r, lo_r_r, lo_z_r;
  logic [61:0]        hi_q_r, hi_r_r, hi_z_r;
  logic [47:0]        fq_r, fr_r, fz_r;
  logic [62:0]        sum_q, sum_r, sum_z;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      px_r <= 63'($signed({1'b0, K_S3_3})) * 63'($signed(in_data.world_x));
      py_r <= 63'($signed({1'b0, K_THIRD})) * 63'($signed(in_data.world_y));
      pr_r <= 63'($signed({1'b0, K_TWOTHIRD})) * 63'($signed(in_data.world_y));
      z_r  <= in_data.world_z;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      nq_r <= 64'(px_r) - 64'(py_r);
      nr_r <= 64'(pr_r);
      nz_r <= {{2{z_r[31]}}, z_r, 30'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      mq_r   <= nq_r[63] ? 62'(-nq_r) : 62'(nq_r);
      mr_r   <= nr_r[63] ? 62'(-nr_r) : 62'(nr_r);
      mz_r   <= nz_r[63] ? 62'(-nz_r) : 62'(nz_r);
      neg2_r <= {nz_r[63], nr_r[63], nq_r[63]};
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      lo_q_r <= 64'(mq_r[31:0]) * 64'(inv_hex_radius);
      lo_r_r <= 64'(mr_r[31:0]) * 64'(inv_hex_radius);
      lo_z_r <= 64'(mz_r[31:0]) * 64'(inv_layer_height);
      hi_q_r <= 62'(mq_r[61:32]) * 62'(inv_hex_radius);
      hi_r_r <= 62'(mr_r[61:32]) * 62'(inv_hex_radius);
      hi_z_r <= 62'(mz_r[61:32]) * 62'(inv_layer_height);
      neg3_r <= neg2_r;
    end
  end

  assign sum_q = {1'b0, hi_q_r} + {31'd0, lo_q_r[63:32]};
  assign sum_r = {1'b0, hi_r_r} + {31'd0, lo_r_r[63:32]};
  assign sum_z = {1'b0, hi_z_r} + {31'd0, lo_z_r[63:32]};

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      fq_r   <= sum_q[61:14];
      fr_r   <= sum_r[61:14];
      fz_r   <= sum_z[61:14];
      neg4_r <= neg3_r;
    end
  end

  assign frac.mag_q = fq_r;
  assign frac.mag_r = fr_r;
  assign frac.mag_z = fz_r;
  assign frac.neg_q = neg4_r[0];
  assign frac.neg_r = neg4_r[1];
  assign frac.neg_z = neg4_r[2];

endmodule

`default_nettype wire

// File: rtl/core/hgs_round.sv
// middle pipeline: per-component rounding, cube rounding and saturation to grid range
`timescale 1ns / 1ps
`default_nettype none

module hgs_round (
  input  logic                             clk,
  input  logic [hgs_pkg::ROUND_STAGES-1:0] stage_en,
  input  hgs_pkg::hgs_frac_t               frac,
  output hgs_pkg::hgs_cell_t               grid_cell
);
  import hgs_pkg::*;

  function automatic logic [33:0] rnd_mag(input logic [48:0] m);
    logic [49:0] s;
    s = {1'b0, m} + 50'h8000;
    return s[49:16];
  endfunction

  function automatic logic [16:0] rnd_err(input logic [15:0] f);
    logic [16:0] e;
    e = f[15] ? (17'h10000 - {1'b0, f}) : {1'b0, f};
    return e;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    logic signed [15:0] s;
    if (v > 36'sd32767) s = 16'sh7fff;
    else if (v < -36'sd32768) s = 16'sh8000;
    else s = v[15:0];
    return s;
  endfunction

  logic signed [48:0] fq_r, fr_r;
  logic [33:0]        rxm_r, rzm_r, rlm_r;
  logic [16:0]        ex0_r, ez0_r, ex1_r, ez1_r, ex2_r, ez2_r, ex3_r, ez3_r, ey3_r;
  logic [2:0]         neg0_r;
  logic signed [49:0] cy_r;
  logic signed [34:0] rx1_r, rz1_r, rl1_r, rx2_r, rz2_r, rl2_r;
  logic signed [34:0] rx3_r, rz3_r, rl3_r, rx4_r, rz4_r, rl4_r, ry4_r, rl5_r;
  logic [48:0]        cym_r;
  logic               cyn2_r, cyn3_r;
  logic [33:0]        rym_r;
  logic               fix_x_r, fix_z_r;
  logic signed [35:0] q5_r, r5_r;
  logic signed [15:0] q6_r, r6_r, l6_r;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      fq_r   <= frac.neg_q ? -$signed({1'b0, frac.mag_q}) : $signed({1'b0, frac.mag_q});
      fr_r   <= frac.neg_r ? -$signed({1'b0, frac.mag_r}) : $signed({1'b0, frac.mag_r});
      rxm_r  <= rnd_mag({1'b0, frac.mag_q});
      rzm_r  <= rnd_mag({1'b0, frac.mag_r});
      rlm_r  <= rnd_mag({1'b0, frac.mag_z});
      ex0_r  <= rnd_err(frac.mag_q[15:0]);
      ez0_r  <= rnd_err(frac.mag_r[15:0]);
      neg0_r <= {frac.neg_z, frac.neg_r, frac.neg_q};
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      cy_r  <= -50'(fq_r) - 50'(fr_r);
      rx1_r <= neg0_r[0] ? -$signed({1'b0, rxm_r}) : $signed({1'b0, rxm_r});
      rz1_r <= neg0_r[1] ? -$signed({1'b0, rzm_r}) : $signed({1'b0, rzm_r});
      rl1_r <= neg0_r[2] ? -$signed({1'b0, rlm_r}) : $signed({1'b0, rlm_r});
      ex1_r <= ex0_r;
      ez1_r <= ez0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      cym_r  <= cy_r[49] ? 49'(-cy_r) : 49'(cy_r);
      cyn2_r <= cy_r[49];
      rx2_r  <= rx1_r;
      rz2_r  <= rz1_r;
      rl2_r  <= rl1_r;
      ex2_r  <= ex1_r;
      ez2_r  <= ez1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      rym_r  <= rnd_mag(cym_r);
      ey3_r  <= rnd_err(cym_r[15:0]);
      cyn3_r <= cyn2_r;
      rx3_r  <= rx2_r;
      rz3_r  <= rz2_r;
      rl3_r  <= rl2_r;
      ex3_r  <= ex2_r;
      ez3_r  <= ez2_r;
    end
  end

  // largest error is recomputed; ties with z fall to z, an x-y tie falls to y
  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      ry4_r   <= cyn3_r ? -$signed({1'b0, rym_r}) : $signed({1'b0, rym_r});
      fix_x_r <= (ex3_r > ey3_r) && (ex3_r > ez3_r);
      fix_z_r <= !((ex3_r > ey3_r) && (ex3_r > ez3_r)) && !(ey3_r > ez3_r);
      rx4_r   <= rx3_r;
      rz4_r   <= rz3_r;
      rl4_r   <= rl3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      q5_r  <= fix_x_r ? (-36'(ry4_r) - 36'(rz4_r)) : 36'(rx4_r);
      r5_r  <= fix_z_r ? (-36'(rx4_r) - 36'(ry4_r)) : 36'(rz4_r);
      rl5_r <= rl4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      q6_r <= sat16(q5_r);
      r6_r <= sat16(r5_r);
      l6_r <= sat16(36'(rl5_r));
    end
  end

  assign grid_cell.q     = q6_r;
  assign grid_cell.r     = r6_r;
  assign grid_cell.layer = l6_r;

endmodule

`default_nettype wire

// File: rtl/core/hgs_map.sv
// back pipeline: cell and layer mapped to world centre with rounding and saturation
`timescale 1ns / 1ps
`default_nettype none

module hgs_map (
  input  logic                           clk,
  input  logic [hgs_pkg::MAP_STAGES-1:0] stage_en,
  input  hgs_pkg::hgs_cell_t             grid_cell,
  input  logic [23:0]                    hex_radius,
  input  logic [23:0]                    layer_height,
  output hgs_pkg::out_item_t             out_item
);
  import hgs_pkg::*;

  function automatic logic [31:0] sat_mag(input logic [42:0] m, input logic neg);
    logic [31:0] res;
    if (!neg) res = (m > 43'h7fff_ffff) ? 32'h7fff_ffff : m[31:0];
    else res = (m > 43'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
    return res;
  endfunction

  logic signed [17:0] a_r;
  logic [25:0]        rad3_r;
  hgs_cell_t          c0_r, c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;
  logic signed [42:0] t1_r, t2_r;
  logic signed [40:0] t3_r;
  logic [41:0]        t1m_r, t2m_r;
  logic [1:0]         neg2_r, neg3_r, neg4_r, neg5_r;
  logic [31:0]        sz2_r, sz3_r, sz4_r, sz5_r, sz6_r;
  logic [62:0]        plo_r;
  logic [40:0]        phi3_r, phi4_r;
  logic [41:0]        sym3_r, sym4_r, sym5_r;
  logic [32:0]        lr_r;
  logic [42:0]        p_r;
  logic [31:0]        sx6_r, sy6_r;
  logic [63:0]        lr_sum;
  logic [42:0]        sy_sum;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      a_r    <= (18'(grid_cell.q) <<< 1) + 18'(grid_cell.r);
      rad3_r <= {2'b00, hex_radius} + {1'b0, hex_radius, 1'b0};
      c0_r   <= grid_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      t1_r <= 43'($signed({1'b0, hex_radius})) * 43'(a_r);
      t2_r <= 43'($signed({1'b0, rad3_r})) * 43'(c0_r.r);
      t3_r <= 41'(c0_r.layer) * 41'($signed({1'b0, layer_height}));
      c1_r <= c0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      t1m_r  <= t1_r[42] ? 42'(-t1_r) : 42'(t1_r);
      t2m_r  <= t2_r[42] ? 42'(-t2_r) : 42'(t2_r);
      neg2_r <= {t2_r[42], t1_r[42]};
      if (t3_r > 41'sd2147483647) sz2_r <= 32'h7fff_ffff;
      else if (t3_r < -41'sd2147483648) sz2_r <= 32'h8000_0000;
      else sz2_r <= t3_r[31:0];
      c2_r <= c1_r;
    end
  end

  assign sy_sum = {1'b0, t2m_r} + 43'd1;

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      plo_r  <= 63'(t1m_r[31:0]) * 63'(K_SQRT3);
      phi3_r <= 41'(t1m_r[41:32]) * 41'(K_SQRT3);
      sym3_r <= sy_sum[42:1];
      neg3_r <= neg2_r;
      sz3_r  <= sz2_r;
      c3_r   <= c2_r;
    end
  end

  assign lr_sum = {1'b0, plo_r} + 64'h4000_0000;

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      lr_r   <= lr_sum[63:31];
      phi4_r <= phi3_r;
      sym4_r <= sym3_r;
      neg4_r <= neg3_r;
      sz4_r  <= sz3_r;
      c4_r   <= c3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      p_r    <= 43'({phi4_r, 1'b0}) + 43'(lr_r);
      sym5_r <= sym4_r;
      neg5_r <= neg4_r;
      sz5_r  <= sz4_r;
      c5_r   <= c4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      sx6_r <= sat_mag(p_r, neg5_r[0]);
      sy6_r <= sat_mag(43'(sym5_r), neg5_r[1]);
      sz6_r <= sz5_r;
      c6_r  <= c5_r;
    end
  end

  assign out_item.cell_q     = c6_r.q;
  assign out_item.cell_r     = c6_r.r;
  assign out_item.cell_layer = c6_r.layer;
  assign out_item.snap_x     = sx6_r;
  assign out_item.snap_y     = sy6_r;
  assign out_item.snap_z     = sz6_r;

endmodule

`default_nettype wire

// File: rtl/core/hex_grid_snap_unit.sv
// top level of the hex grid snap unit: config registers, stage valids and pipeline
//
// Snaps a world point (x, y, z, signed, 8 fraction bits) to a pointy-top hex
// cell with vertical layers and returns the cell, the layer and the world
// position of the cell centre.
// Input channel in_valid / in_ready / in_data, result channel out_valid /
// out_ready / out_data; an item moves when valid and ready are both high.
// Config port: cfg_we, cfg_index, cfg_data; a write lands at the clock edge
// where cfg_we is high. Write registers only while no item is in flight.
// Throughput is one item per cycle while out_ready is high. An item passes
// through the 19 register stages (front scaling multipliers, rounding,
// world mapping) before it is shown on out_data.
// Every stage has its own valid bit; a stage loads whenever out_ready is high or
// it or any later stage is empty, so with out_ready low the pipe keeps taking
// items until all stages are full, and nothing is lost or repeated.
// Synchronous reset clears the stage valids and sets the registers to their
// defaults; no result is shown until an item has gone through.
`timescale 1ns / 1ps
`default_nettype none

module hex_grid_snap_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  hgs_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output hgs_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [hgs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hgs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hgs_pkg::*;

  logic [23:0]           hex_radius_r, layer_height_r;
  logic [31:0]           inv_hex_radius_r, inv_layer_height_r;
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] stage_en;
  hgs_frac_t             frac;
  hgs_cell_t             grid_cell;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_radius_r       <= HEX_RADIUS_RST;
      layer_height_r     <= LAYER_HEIGHT_RST;
      inv_hex_radius_r   <= INV_HEX_RADIUS_RST;
      inv_layer_height_r <= INV_LAYER_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEX_RADIUS:       hex_radius_r       <= cfg_data[23:0];
        REG_LAYER_HEIGHT:     layer_height_r     <= cfg_data[23:0];
        REG_INV_HEX_RADIUS:   inv_hex_radius_r   <= cfg_data;
        REG_INV_LAYER_HEIGHT: inv_layer_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage may load when out_ready is high or any stage from it to the output is free
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_en
    assign stage_en[g] = out_ready || !(&vld_r[NUM_STAGES-1:g]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stage_en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (stage_en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  hgs_scale u_scale (
    .clk              (clk),
    .stage_en         (stage_en[SCALE_STAGES-1:0]),
    .in_data          (in_data),
    .inv_hex_radius   (inv_hex_radius_r),
    .inv_layer_height (inv_layer_height_r),
    .frac             (frac)
  );

  hgs_round u_round (
    .clk       (clk),
    .stage_en  (stage_en[SCALE_STAGES+ROUND_STAGES-1:SCALE_STAGES]),
    .frac      (frac),
    .grid_cell (grid_cell)
  );

  hgs_map u_map (
    .clk          (clk),
    .stage_en     (stage_en[NUM_STAGES-1:SCALE_STAGES+ROUND_STAGES]),
    .grid_cell    (grid_cell),
    .hex_radius   (hex_radius_r),
    .layer_height (layer_height_r),
    .out_item     (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/core/hgs_checker.sv
// port checker for the hex grid snap unit and its bind
`timescale 1ns / 1ps
`default_nettype none

module hgs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input hgs_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result shown straight after reset");

  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready || !out_valid |-> in_ready)
    else $error("input held off although the pipe can advance");

  a_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cell_r == 16'sd0 |-> out_data.snap_y == 32'sd0)
    else $error("row zero mapped to nonzero y");

  a_layer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cell_layer == 16'sd0 |-> out_data.snap_z == 32'sd0)
    else $error("layer zero mapped to nonzero z");

endmodule

bind hex_grid_snap_unit hgs_checker u_hgs_checker (.*);

`default_nettype wire

// File: bench/testbench.sv
// testbench of the hex grid snap unit: directed table, random items, bit-exact predictor
`timescale 1ns / 1ps

module testbench;
  import hgs_pkg::*;

  localparam int IDLE_PCT           = 31;
  localparam int CYCLE_LIMIT        = 200000;
  localparam int SETTLE_CYCLES      = NUM_STAGES + 8;
  localparam int RANDOM_PHASES      = 8;
  localparam int POINTS_PER_PHASE   = 125;
  localparam int QUIET_PHASE        = 3;
  localparam int FIRST_UNMAPPED_REG = 4;

  localparam int PLAN_RESET = 0;
  localparam int PLAN_ZERO  = 1;
  localparam int PLAN_MAX   = 2;
  localparam int PLAN_MIN   = 3;
  localparam int PLAN_TIE   = 4;
  localparam int PLAN_SKEW  = 5;
  localparam int N_PLANS    = 6;
  localparam int N_DIRECTED = 25;

  // grid constants, 2^30 scaled
  localparam longint C_S3_3     = 64'sd619925131;
  localparam longint C_THIRD    = 64'sd357913941;
  localparam longint C_TWOTHIRD = 64'sd715827883;
  localparam longint C_SQRT3    = 64'sd1859775393;
  localparam longint TWO_POW_30 = 64'sd1073741824;
  localparam longint Q16_ONE    = 64'sd65536;
  localparam longint Q16_HALF   = 64'sd32768;
  localparam longint CELL_MIN   = -64'sd32768;
  localparam longint CELL_MAX   = 64'sd32767;
  localparam longint WORLD_MIN  = -64'sd2147483648;
  localparam longint WORLD_MAX  = 64'sd2147483647;

  localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] W_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [31:0] radius;
    logic [31:0] height;
    logic [31:0] inv_radius;
    logic [31:0] inv_height;
  } reg_plan_t;

  typedef struct {
    int        plan;
    in_item_t  pt;
    bit        fixed;
    out_item_t snap;
  } dir_row_t;

  typedef struct {
    bit        fixed;
    out_item_t snap;
  } snap_tag_t;

  reg_plan_t cfg_plan [N_PLANS] = '{
    '{32'd25600, 32'd25600, 32'd167772, 32'd167772},
    '{32'd0, 32'd0, 32'd0, 32'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{32'd1, 32'd1, 32'd1, 32'd1},
    '{32'd256, 32'd25600, 32'd65536, 32'd65536},
    '{32'h0080_0000, 32'd3, 32'hFFFF_FFFF, 32'd7}
  };

  dir_row_t dir_table [N_DIRECTED] = '{
    '{PLAN_RESET, '{32'sd0, 32'sd0, 32'sd0}, 1'b1, '0},
    '{PLAN_RESET, '{32'sd0, 32'sd0, 32'sd25600}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd1, 32'sd0, 32'sd0, 32'sd25600}},
    '{PLAN_RESET, '{32'sd0, 32'sd0, -32'sd25600}, 1'b1,
      '{16'sd0, 16'sd0, -16'sd1, 32'sd0, 32'sd0, -32'sd25600}},
    '{PLAN_RESET, '{32'sd0, 32'sd0, W_MAX}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd32767, 32'sd0, 32'sd0, 32'sd838835200}},
    '{PLAN_RESET, '{32'sd0, 32'sd0, W_MIN}, 1'b1,
      '{16'sd0, 16'sd0, -16'sd32768, 32'sd0, 32'sd0, -32'sd838860800}},
    '{PLAN_RESET, '{W_MAX, W_MAX, 32'sd0}, 1'b0, '0},
    '{PLAN_RESET, '{W_MIN, W_MIN, 32'sd0}, 1'b0, '0},
    '{PLAN_RESET, '{W_MAX, W_MIN, 32'sd12800}, 1'b0, '0},
    '{PLAN_RESET, '{W_MIN, W_MAX, -32'sd1}, 1'b0, '0},
    '{PLAN_RESET, '{32'sd25600, 32'sd0, 32'sd0}, 1'b0, '0},
    '{PLAN_ZERO, '{W_MAX, W_MIN, W_MAX}, 1'b1, '0},
    '{PLAN_ZERO, '{W_MIN, W_MAX, W_MIN}, 1'b1, '0},
    '{PLAN_MAX, '{W_MAX, W_MAX, W_MAX}, 1'b0, '0},
    '{PLAN_MAX, '{W_MIN, 32'sd0, W_MIN}, 1'b0, '0},
    '{PLAN_MAX, '{-32'sd1, -32'sd1, -32'sd1}, 1'b0, '0},
    '{PLAN_MIN, '{W_MAX, W_MIN, W_MAX}, 1'b0, '0},
    '{PLAN_MIN, '{32'sd1, 32'sd1, 32'sd1}, 1'b0, '0},
    '{PLAN_TIE, '{32'sd0, 32'sd0, 32'sd32768}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd1, 32'sd0, 32'sd0, 32'sd25600}},
    '{PLAN_TIE, '{32'sd0, 32'sd0, -32'sd32768}, 1'b1,
      '{16'sd0, 16'sd0, -16'sd1, 32'sd0, 32'sd0, -32'sd25600}},
    '{PLAN_TIE, '{32'sd0, 32'sd0, 32'sd32767}, 1'b1, '0},
    '{PLAN_TIE, '{32'sd0, 32'sd49152, 32'sd0}, 1'b0, '0},
    '{PLAN_TIE, '{32'sd0, -32'sd49152, 32'sd0}, 1'b0, '0},
    '{PLAN_TIE, '{32'sd37837, 32'sd49152, 32'sd98304}, 1'b0, '0},
    '{PLAN_SKEW, '{32'sd12345678, -32'sd7654321, 32'sd1000000}, 1'b0, '0},
    '{PLAN_SKEW, '{W_MIN, W_MIN, W_MIN}, 1'b0, '0}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic [23:0] reg_radius     = 24'd25600;
  logic [23:0] reg_height     = 24'd25600;
  logic [31:0] reg_inv_radius = 32'd167772;
  logic [31:0] reg_inv_height = 32'd167772;

  out_item_t pending_snaps [$];
  snap_tag_t snap_tags [$];
  int        fail_count  = 0;
  int        idle_pct    = IDLE_PCT;
  int        cycle_count = 0;

  hex_grid_snap_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint with_sign(longint m, bit neg);
    return neg ? -m : m;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // num * inv / 2^46, truncated toward zero
  function automatic longint recip_scale(longint num, logic [31:0] inv);
    logic [127:0] wide;
    wide = 128'(mag(num)) * inv;
    return with_sign(longint'(wide >> 46), num < 0);
  endfunction

  function automatic longint round_half_away(longint v);
    return with_sign((mag(v) + Q16_HALF) >> 16, v < 0);
  endfunction

  function automatic out_item_t snap_point(in_item_t pt);
    longint wx, wy, wz, fq, fr, fz, cy, rx, ry, rz, ex, ey, ez, q, r, layer, t;
    logic [127:0] wide;
    out_item_t snap;
    wx = longint'(pt.world_x);
    wy = longint'(pt.world_y);
    wz = longint'(pt.world_z);
    fq = recip_scale(C_S3_3 * wx - C_THIRD * wy, reg_inv_radius);
    fr = recip_scale(C_TWOTHIRD * wy, reg_inv_radius);
    fz = recip_scale(wz * TWO_POW_30, reg_inv_height);
    cy = -fq - fr;
    rx = round_half_away(fq);
    ry = round_half_away(cy);
    rz = round_half_away(fr);
    ex = mag(rx * Q16_ONE - fq);
    ey = mag(ry * Q16_ONE - cy);
    ez = mag(rz * Q16_ONE - fr);
    // largest error is recomputed; ties with z fall to z, an x-y tie falls to y
    if (ex > ey && ex > ez) begin
      rx = -ry - rz;
    end else if (ey > ez) begin
      ry = -rx - rz;
    end else begin
      rz = -rx - ry;
    end
    q     = clamp(rx, CELL_MIN, CELL_MAX);
    r     = clamp(rz, CELL_MIN, CELL_MAX);
    layer = clamp(round_half_away(fz), CELL_MIN, CELL_MAX);
    t = longint'(reg_radius) * (2 * q + r);
    wide = (128'(mag(t)) * 128'(C_SQRT3) + (128'd1 << 30)) >> 31;
    snap.snap_x = 32'(clamp(with_sign(longint'(wide), t < 0), WORLD_MIN, WORLD_MAX));
    t = 3 * longint'(reg_radius) * r;
    snap.snap_y = 32'(clamp(with_sign((mag(t) + 1) >> 1, t < 0), WORLD_MIN, WORLD_MAX));
    snap.snap_z = 32'(clamp(layer * longint'(reg_height), WORLD_MIN, WORLD_MAX));
    snap.cell_q     = 16'(q);
    snap.cell_r     = 16'(r);
    snap.cell_layer = 16'(layer);
    return snap;
  endfunction

  function automatic logic [31:0] recip_of(logic [31:0] raw);
    logic [63:0] quo;
    quo = 64'h1_0000_0000 / 64'(raw);
    return (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
  endfunction

  function automatic reg_plan_t random_plan();
    reg_plan_t plan;
    case ($urandom_range(9))
      0: plan = cfg_plan[$urandom_range(N_PLANS - 1)];
      1, 2: plan = '{$urandom, $urandom, $urandom, $urandom};
      default: begin
        plan.radius     = ($urandom >> $urandom_range(31, 8)) | 32'd1;
        plan.height     = ($urandom >> $urandom_range(31, 8)) | 32'd1;
        plan.inv_radius = recip_of(plan.radius);
        plan.inv_height = recip_of(plan.height);
      end
    endcase
    return plan;
  endfunction

  // coordinate within a few dozen cells or layers of the origin
  function automatic logic signed [31:0] coord_near(longint unit);
    longint span;
    span = (unit == 0) ? Q16_ONE : unit * 40;
    if (span > TWO_POW_30) span = TWO_POW_30;
    return 32'(longint'($urandom_range(32'(2 * span))) - span);
  endfunction

  function automatic in_item_t random_point();
    in_item_t pt;
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 3) begin
      pt = '{$urandom, $urandom, $urandom};
    end else if (pick < 5) begin
      pt.world_x = $signed($urandom) >>> $urandom_range(31);
      pt.world_y = $signed($urandom) >>> $urandom_range(31);
      pt.world_z = $signed($urandom) >>> $urandom_range(31);
    end else begin
      pt.world_x = coord_near(longint'(reg_radius));
      pt.world_y = coord_near(longint'(reg_radius));
      pt.world_z = coord_near(longint'(reg_height));
    end
    return pt;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // called and returns at a falling edge
  task automatic drive_point(input in_item_t pt, input bit fixed, input out_item_t snap);
    snap_tags.push_back('{fixed, snap});
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_grid_regs(input reg_plan_t plan);
    in_valid <= 1'b0;
    while (pending_snaps.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HEX_RADIUS;
    cfg_data  <= plan.radius;
    @(negedge clk);
    cfg_index <= REG_LAYER_HEIGHT;
    cfg_data  <= plan.height;
    @(negedge clk);
    cfg_index <= REG_INV_HEX_RADIUS;
    cfg_data  <= plan.inv_radius;
    @(negedge clk);
    cfg_index <= REG_INV_LAYER_HEIGHT;
    cfg_data  <= plan.inv_height;
    @(negedge clk);
    // writes beyond the register list must be ignored
    cfg_index <= CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, FIRST_UNMAPPED_REG));
    cfg_data  <= $urandom;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_radius     = plan.radius[23:0];
    reg_height     = plan.height[23:0];
    reg_inv_radius = plan.inv_radius;
    reg_inv_height = plan.inv_height;
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    snap_tag_t tag;
    out_item_t want;
    if (rst_n && in_valid && in_ready) begin
      tag = snap_tags.pop_front();
      pending_snaps.push_back(tag.fixed ? tag.snap : snap_point(in_data));
    end
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_snaps.size() == 0) begin
        $error("snap item arrived with none pending");
        fail_count++;
      end else begin
        want = pending_snaps.pop_front();
        check_field("cell_q", 64'(want.cell_q), 64'(out_data.cell_q));
        check_field("cell_r", 64'(want.cell_r), 64'(out_data.cell_r));
        check_field("cell_layer", 64'(want.cell_layer), 64'(out_data.cell_layer));
        check_field("snap_x", 64'(want.snap_x), 64'(out_data.snap_x));
        check_field("snap_y", 64'(want.snap_y), 64'(out_data.snap_y));
        check_field("snap_z", 64'(want.snap_z), 64'(out_data.snap_z));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int cur_plan;
    cur_plan = PLAN_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].plan != cur_plan) begin
        cur_plan = dir_table[i].plan;
        write_grid_regs(cfg_plan[cur_plan]);
      end
      drive_point(dir_table[i].pt, dir_table[i].fixed, dir_table[i].snap);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_grid_regs(random_plan());
      idle_pct = (ph == QUIET_PHASE) ? 0 : IDLE_PCT;
      repeat (POINTS_PER_PHASE) drive_point(random_point(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_snaps.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_snaps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
